// ===== rtl/core/srt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// Record layout, command and status codes, controller states and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int SRT_CAPACITY = 16;
	localparam int SRT_CNT_W    = $clog2(SRT_CAPACITY + 1);

	localparam int CMD_W   = 3;
	localparam int STAT_W  = 3;
	localparam int PRICE_W = 32;
	localparam int MILE_W  = 24;
	localparam int YEAR_W  = 12;
	localparam int BRAND_W = 32;
	localparam int MODEL_W = 32;

	typedef enum logic [CMD_W-1:0] {
		OP_INSERT = 3'd0,
		OP_RANGE  = 3'd1,
		OP_BRAND  = 3'd2,
		OP_REMOVE = 3'd3,
		OP_LIST   = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		RS_EMIT     = 3'd0,
		RS_INSERTED = 3'd1,
		RS_FULL     = 3'd2,
		RS_NONE     = 3'd3,
		RS_REMOVED  = 3'd4
	} rstat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_WR,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [MILE_W-1:0]  mileage;
		logic [YEAR_W-1:0]  year;
		logic [BRAND_W-1:0] brand;
		logic [MODEL_W-1:0] model;
	} record_t;

	localparam int REC_W = $bits(record_t);

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic start;
		logic ins_step;
		logic ins_write;
		logic scan_step;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_known;
		logic in_insert;
		logic full;
		logic empty;
		logic ins_shift;
		logic p_one;
		logic scan_last;
		logic scan_stall;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/srt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_if: command and response channels of the sorted record table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface srt_req_if import srt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [PRICE_W-1:0] key_cents;
	logic [PRICE_W-1:0] range_low;
	logic [PRICE_W-1:0] range_high;
	logic [MILE_W-1:0]  mileage;
	logic [MILE_W-1:0]  mileage_limit;
	logic [YEAR_W-1:0]  model_year;
	logic [BRAND_W-1:0] brand_code;
	logic [MODEL_W-1:0] model_code;

	modport source (
		output valid, command, key_cents, range_low, range_high, mileage,
		       mileage_limit, model_year, brand_code, model_code,
		input  ready
	);
	modport sink (
		input  valid, command, key_cents, range_low, range_high, mileage,
		       mileage_limit, model_year, brand_code, model_code,
		output ready
	);
endinterface

interface srt_rsp_if import srt_pkg::*; #(
	parameter int CNT_W = SRT_CNT_W
) ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [PRICE_W-1:0] price_out;
	logic [MILE_W-1:0]  mileage_out;
	logic [YEAR_W-1:0]  year_out;
	logic [BRAND_W-1:0] brand_out;
	logic [MODEL_W-1:0] model_out;
	logic [CNT_W-1:0]   entries_now;
	logic               last;

	modport source (
		output valid, status, price_out, mileage_out, year_out, brand_out,
		       model_out, entries_now, last,
		input  ready
	);
	modport sink (
		input  valid, status, price_out, mileage_out, year_out, brand_out,
		       model_out, entries_now, last,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/srt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/srt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_ctrl: command sequencer of the sorted record table
// Walks insert shifts and table scans one entry per cycle, a scan holding
// while scan_stall is set, and issues the final response of each command.
// ----------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				// unknown commands are taken and dropped
				if (sts.in_valid && sts.in_known) begin
					ctl.start = 1'b1;
					if (sts.in_insert) begin
						if (sts.full) begin
							state_d = S_FINISH;
						end else if (sts.empty) begin
							state_d = S_INS_WR;
						end else begin
							state_d = S_INS_CMP;
						end
					end else if (sts.empty) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_INS_CMP: begin
				if (sts.ins_shift) begin
					ctl.ins_step = 1'b1;
					if (sts.p_one) begin
						state_d = S_INS_WR;
					end
				end else begin
					ctl.ins_write = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_INS_WR: begin
				ctl.ins_write = 1'b1;
				state_d       = S_FINISH;
			end
			S_SCAN: begin
				if (!sts.scan_stall) begin
					ctl.scan_step = 1'b1;
					if (sts.scan_last) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/srt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_dpath: datapath of the sorted record table
// Record ram, insert position and scan counters, match logic, one pending
// hit for the last flag and the response register.
// ----------------------------------------------------------------------------
module srt_dpath import srt_pkg::*; #(
	parameter int CAPACITY = SRT_CAPACITY
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ctl_t  ctl,
	output sts_t       sts,
	srt_req_if.sink    req,
	srt_rsp_if.source  rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// command registers
	op_t                op_q;
	record_t            new_rec_q;
	logic [PRICE_W-1:0] lo_q, hi_q;
	logic [MILE_W-1:0]  lim_q;
	logic               full_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] p_q, i_q, w_q;
	logic [CNT_W-1:0] cnt_m1, p_m2, i_p1;

	record_t pend_q;
	logic    pend_valid_q;

	// response register
	logic             out_valid_q;
	rstat_t           out_stat_q;
	record_t          out_rec_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	logic             out_ld;
	rstat_t           nx_stat;
	record_t          nx_rec;
	logic [CNT_W-1:0] nx_cnt;
	logic             nx_last;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_wa, ram_ra;
	logic [REC_W-1:0] ram_wd, rd_data;
	record_t          rd_rec;

	logic is_query, hit, keep, out_free;

	srt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (rd_data)
	);

	assign rd_rec   = record_t'(rd_data);
	assign cnt_m1   = count_q - 1'b1;
	assign p_m2     = p_q - CNT_W'(2);
	assign i_p1     = i_q + 1'b1;
	assign is_query = (op_q == OP_RANGE) || (op_q == OP_BRAND) || (op_q == OP_LIST);
	assign keep     = (rd_rec.mileage <= lim_q);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		unique case (op_q)
			OP_RANGE: hit = (rd_rec.price >= lo_q) && (rd_rec.price <= hi_q);
			OP_BRAND: hit = (rd_rec.brand == new_rec_q.brand);
			default:  hit = 1'b1;
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.in_valid   = req.valid;
		sts.in_known   = (req.command <= CMD_W'(OP_LIST));
		sts.in_insert  = (req.command == CMD_W'(OP_INSERT));
		sts.full       = (count_q == CNT_W'(CAPACITY));
		sts.empty      = (count_q == '0);
		sts.ins_shift  = (rd_rec.price > new_rec_q.price);
		sts.p_one      = (p_q == CNT_W'(1));
		sts.scan_last  = (i_p1 == count_q);
		sts.scan_stall = is_query && hit && pend_valid_q && !out_free;
		sts.out_free   = out_free;
	end

	// ram port selection
	always_comb begin
		ram_we = 1'b0;
		ram_wa = '0;
		ram_wd = rd_data;
		ram_re = 1'b0;
		ram_ra = '0;
		if (ctl.start) begin
			ram_re = 1'b1;
			ram_ra = (req.command == CMD_W'(OP_INSERT)) ? cnt_m1[IDX_W-1:0] : '0;
		end
		if (ctl.ins_step) begin
			// move the entry below the gap up by one
			ram_we = 1'b1;
			ram_wa = p_q[IDX_W-1:0];
			ram_re = 1'b1;
			ram_ra = p_m2[IDX_W-1:0];
		end
		if (ctl.ins_write) begin
			ram_we = 1'b1;
			ram_wa = p_q[IDX_W-1:0];
			ram_wd = new_rec_q;
		end
		if (ctl.scan_step) begin
			ram_re = 1'b1;
			ram_ra = i_p1[IDX_W-1:0];
			if (op_q == OP_REMOVE && keep) begin
				ram_we = 1'b1;
				ram_wa = w_q[IDX_W-1:0];
			end
		end
	end

	// response selection
	always_comb begin
		out_ld  = 1'b0;
		nx_stat = RS_EMIT;
		nx_rec  = '0;
		nx_cnt  = count_q;
		nx_last = 1'b0;
		if (ctl.scan_step && is_query && hit && pend_valid_q) begin
			// a newer hit proves the pending one is not the last
			out_ld = 1'b1;
			nx_rec = pend_q;
		end
		if (ctl.finish) begin
			out_ld  = 1'b1;
			nx_last = 1'b1;
			unique case (op_q)
				OP_INSERT: nx_stat = full_q ? RS_FULL : RS_INSERTED;
				OP_REMOVE: begin
					nx_stat = RS_REMOVED;
					nx_cnt  = w_q;
				end
				default: begin
					if (pend_valid_q) begin
						nx_stat = RS_EMIT;
						nx_rec  = pend_q;
					end else begin
						nx_stat = RS_NONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (ctl.ins_write) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.finish && op_q == OP_REMOVE) begin
				count_q <= w_q;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.start) begin
				pend_valid_q <= 1'b0;
			end else if (ctl.scan_step && is_query && hit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q      <= op_t'(req.command);
			new_rec_q <= {req.key_cents, req.mileage, req.model_year, req.brand_code,
			              req.model_code};
			lo_q      <= req.range_low;
			hi_q      <= req.range_high;
			lim_q     <= req.mileage_limit;
			full_q    <= (count_q == CNT_W'(CAPACITY));
			p_q       <= count_q;
			i_q       <= '0;
			w_q       <= '0;
		end
		if (ctl.ins_step) begin
			p_q <= p_q - 1'b1;
		end
		if (ctl.scan_step) begin
			i_q <= i_p1;
			if (op_q == OP_REMOVE && keep) begin
				w_q <= w_q + 1'b1;
			end
			if (is_query && hit) begin
				pend_q <= rd_rec;
			end
		end
		if (out_ld) begin
			out_stat_q <= nx_stat;
			out_rec_q  <= nx_rec;
			out_cnt_q  <= nx_cnt;
			out_last_q <= nx_last;
		end
	end

	assign req.ready       = ctl.in_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_stat_q;
	assign rsp.price_out   = out_rec_q.price;
	assign rsp.mileage_out = out_rec_q.mileage;
	assign rsp.year_out    = out_rec_q.year;
	assign rsp.brand_out   = out_rec_q.brand;
	assign rsp.model_out   = out_rec_q.model;
	assign rsp.entries_now = out_cnt_q;
	assign rsp.last        = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_step |-> p_q != '0)
		else $error("insert shift below the first entry");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_step && op_q == OP_REMOVE |-> w_q <= i_q)
		else $error("remove write pointer ahead of read pointer");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> out_valid_q)
		else $error("final response not presented");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_record_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_record_table: price-ordered record table with query commands
// Holds up to CAPACITY records in ascending price order; takes insert, price
// range query, brand query, remove above mileage and list all commands.
// ----------------------------------------------------------------------------
// usage:
//   req carries one command per transaction, taken only while the block is
//   idle; codes 5 to 7 are taken and dropped with no response.
//   rsp returns the responses of a command in order, last marks the final
//   one; queries return one transaction per matching record, or a single
//   nothing-matched transaction.
//   insert: ram walk from the top, moving each record priced above the
//   new one up by one before the new record is written; a full table
//   goes straight to the final response. queries and remove: one stored
//   record per cycle while the scan is not stalled, through one ram read
//   port; the next command is taken the cycle after the final response
//   is loaded into the response register. a stalled rsp holds the scan
//   once a second hit waits behind the pending one; the response register
//   lets the final response wait while the block goes back to idle.
//   reset empties the table at once (count cleared, no clearing pass).
// ----------------------------------------------------------------------------
module sorted_record_table import srt_pkg::*; #(
	parameter int CAPACITY = SRT_CAPACITY
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srt_req_if.sink   req,
	srt_rsp_if.source rsp
);

	ctl_t ctl;
	sts_t sts;

	srt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	srt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
